@@ src/gb32_pkg.sv @@
// Shared types, constants and the symbol table of the grouped base32 formatter.
// Has no dependencies; every other file of the block uses it.
`default_nettype none

package gb32_pkg;

  localparam int SYM_BITS = 5;
  localparam int Q_DEPTH  = 2;

  typedef logic [SYM_BITS-1:0] sym_t;
  typedef logic [6:0]          char_t;

  localparam char_t SPACE_CHAR = 7'd32;

  // One decoded byte: one or two symbols, each with an optional leading space.
  typedef struct packed {
    sym_t sym0;
    sym_t sym1;
    logic two_syms;
    logic space0;
    logic space1;
    logic code_end;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    PH_SP0  = 4'b0001,
    PH_SYM0 = 4'b0010,
    PH_SP1  = 4'b0100,
    PH_SYM1 = 4'b1000
  } phase_t;

  // Crockford alphabet: 0-9 then A-Z without I, L, O and U.
  function automatic char_t sym_ascii(input sym_t s);
    char_t c;
    case (s)
      5'd0:  c = 7'h30;
      5'd1:  c = 7'h31;
      5'd2:  c = 7'h32;
      5'd3:  c = 7'h33;
      5'd4:  c = 7'h34;
      5'd5:  c = 7'h35;
      5'd6:  c = 7'h36;
      5'd7:  c = 7'h37;
      5'd8:  c = 7'h38;
      5'd9:  c = 7'h39;
      5'd10: c = 7'h41;
      5'd11: c = 7'h42;
      5'd12: c = 7'h43;
      5'd13: c = 7'h44;
      5'd14: c = 7'h45;
      5'd15: c = 7'h46;
      5'd16: c = 7'h47;
      5'd17: c = 7'h48;
      5'd18: c = 7'h4A;
      5'd19: c = 7'h4B;
      5'd20: c = 7'h4D;
      5'd21: c = 7'h4E;
      5'd22: c = 7'h50;
      5'd23: c = 7'h51;
      5'd24: c = 7'h52;
      5'd25: c = 7'h53;
      5'd26: c = 7'h54;
      5'd27: c = 7'h56;
      5'd28: c = 7'h57;
      5'd29: c = 7'h58;
      5'd30: c = 7'h59;
      default: c = 7'h5A;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/gb32_ifs.sv @@
// Channel interfaces of the formatter: digest byte input and character output.
// Uses gb32_pkg for the character type.
`default_nettype none

interface gb32_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  modport source (output valid, output digest_byte, input ready);
  modport sink   (input valid, input digest_byte, output ready);
endinterface

interface gb32_char_if;
  logic                valid;
  logic                ready;
  gb32_pkg::char_t     char_code;
  logic                run_last;
  logic                code_done;
  modport source (output valid, output char_code, output run_last, output code_done,
                  input ready);
  modport sink   (input valid, input char_code, input run_last, input code_done,
                  output ready);
endinterface

`default_nettype wire

@@ src/gb32_front.sv @@
// Front end: shifts digest bytes into the bit buffer and decodes each into a queue entry.
// Uses gb32_pkg for the entry type.
`default_nettype none

module gb32_front #(
  parameter int BYTES_PER_CODE = 30,
  parameter int GROUP_SIZE     = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire logic [7:0]      digest_byte,
  output gb32_pkg::entry_t     entry
);

  localparam int GRP_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam logic [GRP_W-1:0] GRP_MAX = GRP_W'(GROUP_SIZE - 1);

  logic [3:0]       buf_r, buf_nxt;
  logic [2:0]       pend_r, pend_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic             started_r, started_nxt;
  logic [4:0]       bytes_r, bytes_nxt;

  logic [11:0]      cat;
  logic [3:0]       nbits;
  logic [3:0]       pend_new;
  logic [3:0]       mask;
  logic [GRP_W-1:0] grp_after0, grp_after1;
  logic             two;
  logic             final_byte;

  always_comb begin
    cat        = {buf_r, digest_byte};
    nbits      = {1'b0, pend_r} + 4'd8;
    two        = (nbits >= 4'd10);
    pend_new   = two ? (nbits - 4'd10) : (nbits - 4'd5);
    mask       = 4'((5'd1 << pend_new) - 5'd1);
    final_byte = ({1'b0, bytes_r} + 6'd1) >= 6'(BYTES_PER_CODE);

    grp_after0 = (grp_r == GRP_MAX) ? '0 : grp_r + GRP_W'(1);
    grp_after1 = (grp_after0 == GRP_MAX) ? '0 : grp_after0 + GRP_W'(1);

    entry.sym0     = gb32_pkg::sym_t'(cat >> (nbits - 4'd5));
    entry.sym1     = gb32_pkg::sym_t'(cat >> (nbits - 4'd10));
    entry.two_syms = two;
    entry.space0   = started_r && (grp_r == '0);
    entry.space1   = (grp_after0 == '0);
    entry.code_end = final_byte;

    buf_nxt     = buf_r;
    pend_nxt    = pend_r;
    grp_nxt     = grp_r;
    started_nxt = started_r;
    bytes_nxt   = bytes_r;
    if (push) begin
      if (final_byte) begin
        buf_nxt     = '0;
        pend_nxt    = '0;
        grp_nxt     = '0;
        started_nxt = 1'b0;
        bytes_nxt   = '0;
      end else begin
        buf_nxt     = cat[3:0] & mask;
        pend_nxt    = pend_new[2:0];
        grp_nxt     = two ? grp_after1 : grp_after0;
        started_nxt = 1'b1;
        bytes_nxt   = bytes_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r     <= '0;
      pend_r    <= '0;
      grp_r     <= '0;
      started_r <= 1'b0;
      bytes_r   <= '0;
    end else begin
      buf_r     <= buf_nxt;
      pend_r    <= pend_nxt;
      grp_r     <= grp_nxt;
      started_r <= started_nxt;
      bytes_r   <= bytes_nxt;
    end
  end

  a_pend_small: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r < 3'd5)
    else $error("pending bit count out of range");

endmodule

`default_nettype wire

@@ src/gb32_queue.sv @@
// Short entry queue between the front decoder and the back serializer.
// Uses gb32_pkg for the entry and status types.
`default_nettype none

module gb32_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  gb32_pkg::entry_t       push_data,
  input  wire logic              pop,
  output gb32_pkg::entry_t       head,
  output gb32_pkg::q_status_t    status
);

  localparam int PTR_W = (gb32_pkg::Q_DEPTH > 1) ? $clog2(gb32_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(gb32_pkg::Q_DEPTH + 1);

  gb32_pkg::entry_t  mem_r [gb32_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(gb32_pkg::Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    status.full  = (cnt_r == CNT_W'(gb32_pkg::Q_DEPTH));
    status.empty = (cnt_r == '0);
    head         = mem_r[rd_r];
    wr_nxt  = push ? ptr_inc(wr_r) : wr_r;
    rd_nxt  = pop  ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

@@ src/gb32_back.sv @@
// Back end: walks queue entries, one char per cycle unless stalled, into the output register.
// Uses gb32_pkg for the entry, phase and symbol table.
`default_nettype none

module gb32_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  gb32_pkg::entry_t       head,
  input  gb32_pkg::q_status_t    status,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gb32_pkg::char_t        out_char,
  output logic                   out_last,
  output logic                   out_done
);

  gb32_pkg::phase_t phase_r, phase_nxt, eff;
  logic             valid_r, valid_nxt;
  gb32_pkg::char_t  char_r, char_nxt;
  logic             last_r, last_nxt, done_r, done_nxt;
  gb32_pkg::char_t  cur_char;
  logic             cur_last;
  logic             load;

  always_comb begin
    // Skip a space slot that the entry does not need.
    unique case (phase_r)
      gb32_pkg::PH_SP0:  eff = head.space0 ? gb32_pkg::PH_SP0 : gb32_pkg::PH_SYM0;
      gb32_pkg::PH_SYM0: eff = gb32_pkg::PH_SYM0;
      gb32_pkg::PH_SP1:  eff = head.space1 ? gb32_pkg::PH_SP1 : gb32_pkg::PH_SYM1;
      gb32_pkg::PH_SYM1: eff = gb32_pkg::PH_SYM1;
      default:           eff = gb32_pkg::PH_SYM0;
    endcase

    unique case (eff)
      gb32_pkg::PH_SYM0: cur_char = gb32_pkg::sym_ascii(head.sym0);
      gb32_pkg::PH_SYM1: cur_char = gb32_pkg::sym_ascii(head.sym1);
      default:           cur_char = gb32_pkg::SPACE_CHAR;
    endcase
    cur_last = ((eff == gb32_pkg::PH_SYM0) && !head.two_syms) || (eff == gb32_pkg::PH_SYM1);

    load = !status.empty && (!valid_r || out_ready);
    pop  = load && cur_last;

    phase_nxt = phase_r;
    if (load) begin
      if (cur_last) begin
        phase_nxt = gb32_pkg::PH_SP0;
      end else begin
        unique case (eff)
          gb32_pkg::PH_SP0:  phase_nxt = gb32_pkg::PH_SYM0;
          gb32_pkg::PH_SYM0: phase_nxt = gb32_pkg::PH_SP1;
          default:           phase_nxt = gb32_pkg::PH_SYM1;
        endcase
      end
    end

    valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
    char_nxt  = load ? cur_char : char_r;
    last_nxt  = load ? cur_last : last_r;
    done_nxt  = load ? (cur_last && head.code_end) : done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gb32_pkg::PH_SP0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;
  assign out_done  = done_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && done_r) |-> last_r)
    else $error("code end flagged on a character that does not close its byte");

  a_last_is_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && last_r) |-> (char_r != gb32_pkg::SPACE_CHAR))
    else $error("a byte closed on a space");

endmodule

`default_nettype wire

@@ src/grouped_base32_code_formatter_core.sv @@
// Top level of the grouped base32 code formatter: front decoder, entry queue, back serializer.
// Depends on gb32_pkg, gb32_ifs, gb32_front, gb32_queue and gb32_back.
//
//   channel   direction  payload                               moves
//   in_ch     sink       digest_byte[7:0]                      one digest byte per request
//   out_ch    source     char_code[6:0], run_last, code_done   one character per request
//
// A byte is taken in any cycle in which the two-entry queue has room, so bytes can arrive
// back to back. The back end sends one character per cycle while out_ch is not stalled; a
// byte makes one or two symbols plus at most one space (two spaces when GROUP_SIZE is 1),
// so the character serializer sets the sustained byte rate (59 characters for a 30-byte
// code at the defaults).
// The first character of a byte passes through the entry queue and then the output register.
// Reset clears the bit buffer, counters, queue and output valid bit; no clearing pass follows.
// Stalls on the output hold the character register and back the queue up into in_ch.ready.
`default_nettype none

module grouped_base32_code_formatter_core #(
  parameter int BYTES_PER_CODE = 30,
  parameter int GROUP_SIZE     = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  gb32_byte_if.sink    in_ch,
  gb32_char_if.source  out_ch
);

  gb32_pkg::entry_t    new_entry;
  gb32_pkg::entry_t    head;
  gb32_pkg::q_status_t q_status;
  logic                push;
  logic                pop;

  // A request on the input side is taken whenever the queue can hold its entry.
  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  // The front decodes the byte in the same cycle it is accepted and holds the
  // bit buffer and the group and byte counters of the current code.
  gb32_front #(
    .BYTES_PER_CODE (BYTES_PER_CODE),
    .GROUP_SIZE     (GROUP_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .digest_byte (in_ch.digest_byte),
    .entry       (new_entry)
  );

  gb32_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (new_entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // The back walks the space and symbol slots of the head entry and retires it
  // with the character that closes the byte.
  gb32_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (q_status),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.char_code),
    .out_last  (out_ch.run_last),
    .out_done  (out_ch.code_done)
  );

endmodule

`default_nettype wire

@@ test/gb32_char_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the grouped base32 formatter: predicts the characters of every accepted
// digest byte and compares them with the accepted output characters.
// Depends on gb32_pkg and the channel interfaces of gb32_ifs.

module gb32_char_checker #(
  parameter int BYTES_PER_CODE = 30,
  parameter int GROUP_SIZE     = 4
) (
  input  logic clk,
  input  logic rst_n,
  gb32_byte_if in_ch,
  gb32_char_if out_ch,
  output int   fail_count,
  output int   chars_outstanding
);

  typedef struct packed {
    gb32_pkg::char_t char_code;
    logic            run_last;
    logic            code_done;
  } char_item_t;

  localparam bit [8*32-1:0] CROCKFORD = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
  localparam int GROUP = (GROUP_SIZE < 1) ? 1 : GROUP_SIZE;

  char_item_t  char_q[$];
  logic [11:0] bit_buf;
  logic [2:0]  bits_held;
  logic [5:0]  syms_in_code;
  logic [4:0]  bytes_in_code;
  int          mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic gb32_pkg::char_t symbol_char(input gb32_pkg::sym_t s);
    logic [7:0] c;
    c = CROCKFORD[8*(31 - int'(s)) +: 8];
    return c[6:0];
  endfunction

  task automatic restart_code();
    bit_buf       = '0;
    bits_held     = '0;
    syms_in_code  = '0;
    bytes_in_code = '0;
  endtask

  // Shifts one byte in and queues the spaces and symbols that it completes.
  task automatic encode_byte(input logic [7:0] b);
    char_item_t res [4];
    int         n;
    int         avail;
    logic       final_byte;
    n          = 0;
    bit_buf    = {bit_buf[3:0], b};
    avail      = int'(bits_held) + 8;
    final_byte = (int'(bytes_in_code) + 1) >= BYTES_PER_CODE;
    while (avail >= gb32_pkg::SYM_BITS) begin
      avail -= gb32_pkg::SYM_BITS;
      if (syms_in_code != 6'd0 && (int'(syms_in_code) % GROUP) == 0) begin
        res[n] = '{gb32_pkg::SPACE_CHAR, 1'b0, 1'b0};
        n++;
      end
      res[n] = '{symbol_char(gb32_pkg::sym_t'(bit_buf >> avail)), 1'b0, 1'b0};
      n++;
      syms_in_code = syms_in_code + 6'd1;
    end
    bit_buf   = bit_buf & ((12'd1 << avail) - 12'd1);
    bits_held = 3'(avail);
    res[n-1].run_last = 1'b1;
    if (final_byte) begin
      res[n-1].code_done = 1'b1;
      restart_code();
    end else begin
      bytes_in_code = bytes_in_code + 5'd1;
    end
    for (int i = 0; i < n; i++) begin
      char_q.push_back(res[i]);
    end
  endtask

  always @(posedge clk) begin
    char_item_t want;
    if (!rst_n) begin
      restart_code();
      char_q.delete();
      chars_outstanding <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        encode_byte(in_ch.digest_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (char_q.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h arrived with nothing expected",
                                    out_ch.char_code));
        end else begin
          want = char_q.pop_front();
          if (out_ch.char_code !== want.char_code) begin
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                      out_ch.char_code, want.char_code));
          end
          if (out_ch.run_last !== want.run_last) begin
            report_mismatch($sformatf("run_last %b, expected %b on char 0x%02h",
                                      out_ch.run_last, want.run_last, want.char_code));
          end
          if (out_ch.code_done !== want.code_done) begin
            report_mismatch($sformatf("code_done %b, expected %b on char 0x%02h",
                                      out_ch.code_done, want.code_done, want.char_code));
          end
        end
      end
      chars_outstanding <= char_q.size();
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Top of the formatter testbench: clock, reset, digest byte requests, output stalls, verdict.
// Depends on gb32_pkg, gb32_ifs, grouped_base32_code_formatter_core and gb32_char_checker.

module testbench;

  localparam int BYTES_PER_CODE = 30;
  localparam int GROUP_SIZE     = 4;
  localparam int RANDOM_CODES   = 10;   // whole codes after the directed one
  localparam int HOLD_CYCLES    = 60;   // long output hold, well past the queue depth
  localparam int DRAIN_CYCLES   = 8;    // first character passes the queue and the output register after a request

  // Content patterns for a whole random digest.
  typedef enum int {
    DIGEST_ZERO,
    DIGEST_ONES,
    DIGEST_SPARSE,
    DIGEST_DENSE,
    DIGEST_RANDOM
  } digest_kind_t;

  // How often the receiver takes a character.
  typedef enum int {
    RX_STEADY,
    RX_LIGHT,
    RX_HALF,
    RX_HEAVY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   chars_outstanding;
  int   stall_asks = 0;
  int   burst_left = 0;

  // Directed bytes: the extremes, single set and cleared bits, and patterns that split
  // across symbol boundaries in different ways.
  logic [7:0] corner_bytes [24] = '{
    8'h00, 8'hFF, 8'h80, 8'h01, 8'h40, 8'h02, 8'h20, 8'h04,
    8'h10, 8'h08, 8'hAA, 8'h55, 8'hFE, 8'h7F, 8'hF8, 8'h07,
    8'h1F, 8'hE0, 8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h00, 8'hFF
  };

  gb32_byte_if in_ch ();
  gb32_char_if out_ch ();

  grouped_base32_code_formatter_core #(
    .BYTES_PER_CODE(BYTES_PER_CODE),
    .GROUP_SIZE    (GROUP_SIZE)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // The checker sits beside the block and only watches both channels.
  gb32_char_checker #(
    .BYTES_PER_CODE(BYTES_PER_CODE),
    .GROUP_SIZE    (GROUP_SIZE)
  ) char_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .fail_count       (fail_count),
    .chars_outstanding(chars_outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard limit on the run. The slowest correct run is a few tens of microseconds.
  initial begin
    #2000000;
    $display("FAIL grouped_base32_code_formatter_core");
    $finish;
  end

  function automatic logic [7:0] digest_byte_of(input digest_kind_t kind);
    logic [7:0] b;
    case (kind)
      DIGEST_ZERO:   b = 8'h00;
      DIGEST_ONES:   b = 8'hFF;
      DIGEST_SPARSE: b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'(1 << $urandom_range(0, 7));
      DIGEST_DENSE:  b = ~(8'(1 << $urandom_range(0, 7)));
      default:       b = 8'($urandom);
    endcase
    return b;
  endfunction

  // Presents one byte and returns at the edge where the request is taken. The valid
  // stays high so the next byte can follow back to back.
  task automatic send_byte(input logic [7:0] b);
    in_ch.valid       <= 1'b1;
    in_ch.digest_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drops valid for a number of cycles; the data bus carries junk meanwhile.
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.digest_byte <= 8'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Sends in bursts of random length. A gap may be empty, and now and then it is
  // long enough for the block to run completely dry. Gapless stretches skip all of this.
  task automatic send_paced(input logic [7:0] b, input bit gapless);
    if (!gapless && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      pause_sender(($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                               : $urandom_range(0, 4));
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    send_byte(b);
  endtask

  // Receiver. It keeps switching between random stall patterns, which include runs
  // with ready held high. When the stimulus asks for it, it holds ready low for a long
  // stretch so the queue fills and the block pushes back on its input.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       stalls_served;
    mode          = RX_STEADY;
    mode_left     = 0;
    stalls_served = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_asks != stalls_served) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stalls_served++;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          RX_STEADY: out_ch.ready <= 1'b1;
          RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:   out_ch.ready <= ($urandom_range(0, 1) != 0);
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus. The first code is the directed one: the corner bytes back to back, then
  // random bytes up to the code boundary, so the random codes that follow start aligned.
  // The first random code is an all-zero digest, which must encode as a code of zeros.
  initial begin : stimulus
    digest_kind_t kind;
    in_ch.valid       <= 1'b0;
    in_ch.digest_byte <= 8'h00;
    rst_n             <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_bytes[i]) begin
      send_paced(corner_bytes[i], 1'b1);
    end
    for (int i = $size(corner_bytes); i < BYTES_PER_CODE; i++) begin
      send_paced(8'($urandom), 1'b0);
    end

    for (int code = 0; code < RANDOM_CODES; code++) begin
      if (code == 0) begin
        kind = DIGEST_ZERO;
      end else begin
        case ($urandom_range(0, 9))
          0:       kind = DIGEST_ZERO;
          1:       kind = DIGEST_ONES;
          2:       kind = DIGEST_SPARSE;
          3:       kind = DIGEST_DENSE;
          default: kind = DIGEST_RANDOM;
        endcase
      end
      // Ask for the long output hold and keep offering bytes without gaps meanwhile.
      if (code == 3) begin
        stall_asks <= stall_asks + 1;
      end
      // Let the block drain completely before this code starts.
      if (code == 6) begin
        pause_sender(1);
        while (chars_outstanding != 0) @(posedge clk);
      end
      for (int k = 0; k < BYTES_PER_CODE; k++) begin
        send_paced(digest_byte_of(kind), code == 3 || code == 8);
      end
    end

    pause_sender(1);
    while (chars_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && chars_outstanding == 0) begin
      $display("PASS grouped_base32_code_formatter_core");
    end else begin
      $display("FAIL grouped_base32_code_formatter_core");
    end
    $finish;
  end

endmodule

@@ grouped_base32_code_formatter_core.f @@
src/gb32_pkg.sv
src/gb32_ifs.sv
src/gb32_front.sv
src/gb32_queue.sv
src/gb32_back.sv
src/grouped_base32_code_formatter_core.sv
test/gb32_char_checker.sv
test/testbench.sv
